/* design/oac_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Object cache package
// Sizes, slot and write-command types, and request codes that the cache
// modules share.
// ----------------------------------------------------------------------------
package oac_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 17;
  localparam int STAMP_W  = 32;
  localparam int SLOT_W   = 4;

  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_ADD    = 1'b1;

  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [STAMP_W-1:0]  stamp;
  } slot_t;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    idx;
    logic                set_data;
    logic                set_tag;
    logic [STAMP_W-1:0]  stamp;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } wr_cmd_t;

endpackage

/* design/oac_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Object cache slot cell
// Holds one slot. It takes its neighbor's slot on a shift, or is updated in
// place by a write command when selected.
// ----------------------------------------------------------------------------
module oac_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic             sel,
  input  oac_pkg::slot_t   nbr,
  input  oac_pkg::wr_cmd_t wr,
  output oac_pkg::slot_t   slot
);

  // Reset clears the whole slot. A shift copies the neighbor, and a selected
  // write always refreshes the stamp.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (shift) begin
      slot <= nbr;
    end else if (sel) begin
      slot.stamp <= wr.stamp;
      if (wr.set_tag) begin
        slot.valid <= 1'b1;
        slot.key   <= wr.key;
      end
      if (wr.set_data) begin
        slot.handle <= wr.handle;
        slot.size   <= wr.size;
      end
    end
  end

endmodule

/* design/oac_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Object cache controller
// Watches the head of the rotating slot chain, finds the key match and the
// least recently used slot, then issues at most one write and the result.
// ----------------------------------------------------------------------------
module oac_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action,
  input  logic [oac_pkg::KEY_W-1:0]       key,
  input  logic [oac_pkg::HANDLE_W-1:0]    value_handle,
  input  logic [oac_pkg::SIZE_W-1:0]      object_size,
  input  oac_pkg::slot_t                  head,
  output logic                            shift,
  output oac_pkg::wr_cmd_t                wr,
  output logic                            done,
  output logic                            hit,
  output logic [oac_pkg::SLOT_W-1:0]      slot_index,
  output logic [oac_pkg::HANDLE_W-1:0]    found_handle,
  output logic [oac_pkg::SIZE_W-1:0]      found_size,
  output logic                            evicted
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t                          state;
  logic [oac_pkg::IDX_W-1:0]       scan_cnt;
  logic                            req_action;
  logic [oac_pkg::KEY_W-1:0]       req_key;
  logic [oac_pkg::HANDLE_W-1:0]    req_handle;
  logic [oac_pkg::SIZE_W-1:0]      req_size;
  logic                            found;
  logic [oac_pkg::IDX_W-1:0]       found_idx;
  logic [oac_pkg::HANDLE_W-1:0]    hit_handle;
  logic [oac_pkg::SIZE_W-1:0]      hit_size;
  logic [oac_pkg::STAMP_W-1:0]     min_stamp;
  logic [oac_pkg::IDX_W-1:0]       victim_idx;
  logic                            victim_valid;
  logic [oac_pkg::STAMP_W-1:0]     use_counter;
  logic [oac_pkg::STAMP_W-1:0]     stamp_next;
  logic                            key_match;
  logic                            take_min;
  logic                            accept;
  logic                            last_step;
  logic                            is_add;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign shift     = (state == ST_SCAN);
  assign last_step = (scan_cnt == oac_pkg::IDX_W'(oac_pkg::ENTRIES - 1));
  assign is_add    = (req_action == oac_pkg::ACT_ADD);
  assign key_match = head.valid && (head.key == req_key);
  assign take_min  = (scan_cnt == '0) || (head.stamp < min_stamp);

  // The use counter saturates at its maximum.
  assign stamp_next = (use_counter == oac_pkg::STAMP_MAX) ? use_counter
                                                          : use_counter + 1'b1;

  always_comb begin
    wr          = '0;
    wr.en       = (state == ST_WRITE) && (found || is_add);
    wr.idx      = found ? found_idx : victim_idx;
    wr.set_data = is_add;
    wr.set_tag  = is_add && !found;
    wr.stamp    = stamp_next;
    wr.key      = req_key;
    wr.handle   = req_handle;
    wr.size     = req_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      scan_cnt    <= '0;
      found       <= 1'b0;
      done        <= 1'b0;
      use_counter <= '0;
    end else begin
      done <= (state == ST_WRITE);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state    <= ST_SCAN;
            scan_cnt <= '0;
            found    <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (key_match) begin
            found <= 1'b1;
          end
          scan_cnt <= scan_cnt + 1'b1;
          if (last_step) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (wr.en) begin
            use_counter <= stamp_next;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_key    <= key;
      req_handle <= value_handle;
      req_size   <= object_size;
    end
    if (state == ST_SCAN) begin
      // The first match in slot order wins.
      if (key_match && !found) begin
        found_idx  <= scan_cnt;
        hit_handle <= head.handle;
        hit_size   <= head.size;
      end
      // Strict compare keeps the lowest slot on equal stamps.
      if (take_min) begin
        min_stamp    <= head.stamp;
        victim_idx   <= scan_cnt;
        victim_valid <= head.valid;
      end
    end
    if (state == ST_WRITE) begin
      hit          <= found;
      evicted      <= is_add && !found && victim_valid;
      found_handle <= (found && !is_add) ? hit_handle : '0;
      found_size   <= (found && !is_add) ? hit_size : '0;
      if (found) begin
        slot_index <= oac_pkg::SLOT_W'(found_idx);
      end else if (is_add) begin
        slot_index <= oac_pkg::SLOT_W'(victim_idx);
      end else begin
        slot_index <= '0;
      end
    end
  end

endmodule

/* design/lru_fully_associative_object_cache_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU fully associative object cache
// A table of slots, each with a key, a value handle, an object size and a
// use stamp, served by lookup and add requests with least recently used
// replacement.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Busy stays high
// until the request is through, so the unit takes no new request before
// then: the slots sit in a ring of cells that rotates once past the
// controller, one slot per cycle, and a write state then updates the
// chosen slot. The result appears in the cycle after that write state, with
// done high for exactly one cycle; the receiver cannot stall it, so it must
// capture the result ports whenever done is high. A lookup that hits returns
// the slot's handle and size and makes the slot most recently used. A lookup
// miss returns zeros and changes nothing. An add whose key is present
// overwrites handle and size in place and reports hit with that slot. An add
// of a new key takes the slot with the oldest stamp, the lowest slot on
// ties, so empty slots fill first; evicted tells whether a live entry was
// displaced. The use counter stops at its maximum rather than wrapping. With
// more than 16 slots, slot_index carries the low four bits of the slot.
// ----------------------------------------------------------------------------
module lru_fully_associative_object_cache_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action,
  input  logic [oac_pkg::KEY_W-1:0]       key,
  input  logic [oac_pkg::HANDLE_W-1:0]    value_handle,
  input  logic [oac_pkg::SIZE_W-1:0]      object_size,
  output logic                            done,
  output logic                            hit,
  output logic [oac_pkg::SLOT_W-1:0]      slot_index,
  output logic [oac_pkg::HANDLE_W-1:0]    found_handle,
  output logic [oac_pkg::SIZE_W-1:0]      found_size,
  output logic                            evicted
);

  oac_pkg::slot_t   slots [oac_pkg::ENTRIES];
  oac_pkg::wr_cmd_t wr;
  logic             shift;

  // Each cell takes the next one's slot on a shift, and the last one closes
  // the ring from cell zero. After a full rotation every slot is back home,
  // so the write that follows can address cells by slot number.
  for (genvar i = 0; i < oac_pkg::ENTRIES; i++) begin : g_cell
    logic sel;

    assign sel = wr.en && (wr.idx == oac_pkg::IDX_W'(i));

    oac_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .sel   (sel),
      .nbr   (slots[(i + 1) % oac_pkg::ENTRIES]),
      .wr    (wr),
      .slot  (slots[i])
    );
  end

  // Cell zero is the head of the ring: during the scan it shows slot s in
  // step s.
  oac_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .key          (key),
    .value_handle (value_handle),
    .object_size  (object_size),
    .head         (slots[0]),
    .shift        (shift),
    .wr           (wr),
    .done         (done),
    .hit          (hit),
    .slot_index   (slot_index),
    .found_handle (found_handle),
    .found_size   (found_size),
    .evicted      (evicted)
  );

endmodule
